@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed: lbl");

// expression that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition: lbl");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ hw/rtl/nbs_pkg.sv @@
package nbs_pkg;

    localparam int NAME_LEN    = 15;
    localparam int ENTRY_BYTES = 18;
    localparam int RESULTS     = 2 * NAME_LEN;

    localparam int POS_W = 5;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [POS_W-1:0] POS_SUFFIX = POS_W'(NAME_LEN);
    localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(NAME_LEN + 1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(ENTRY_BYTES - 1);

    localparam logic [7:0] SUFFIX_WG   = 8'h00;
    localparam logic [7:0] SUFFIX_HOST = 8'h20;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // element 0 is the first character
    typedef logic [NAME_LEN-1:0][7:0] t_name;

    typedef struct packed {
        logic  fail;
        t_name host;
        t_name group;
    } t_snap;

    localparam t_name DEFAULT_GROUP = t_name'({48'h0, 72'("PUORGKROW")});

endpackage

@@ hw/rtl/nbstat_name_table_picker.sv @@
// node-status name table picker
// input channel: one table byte per word (i_in_valid / o_in_ready), the count
// byte flagged by i_first_byte, the final byte by i_last_byte.
// output channel: one name character per word (o_out_valid / i_out_ready);
// 15 host name bytes then 15 workgroup bytes, zero padded, or one failure
// word with o_status set when no usable host name was seen.
// a byte is held in the input register and parsed from there;
// the first result of a run is valid in the cycle after the last byte is taken,
// provided the previous run has drained.
// throughput: one byte per cycle; a run drains at one word per cycle, so a
// last byte waits in the input register until the previous run's final word
// is taken. other bytes keep flowing while results drain.
// a receiver stall only holds the output shift line; parsing continues.
// reset (synchronous, active low) empties both registers and the run state.
`include "assert_macros.svh"

module nbstat_name_table_picker import nbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_which_name,
    output logic       o_status,
    output logic       o_last_result
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_first;
    logic       r_in_last;
    logic       take;
    logic       emit_free;
    t_snap      snap;

    assign take       = r_in_valid && (!r_in_last || emit_free);
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
    end

    nbs_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (r_in_data),
        .i_first (r_in_first),
        .i_last  (r_in_last),
        .o_snap  (snap)
    );

    nbs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && r_in_last),
        .i_snap      (snap),
        .i_out_ready (i_out_ready),
        .o_free      (emit_free),
        .o_valid     (o_out_valid),
        .o_byte      (o_out_byte),
        .o_which     (o_which_name),
        .o_status    (o_status),
        .o_last      (o_last_result)
    );

    // a failure word stands alone
    `ASSERT_CLK(a_fail_single, i_clk, i_rst_n, (o_out_valid && o_status) |-> (o_last_result && !o_which_name && o_out_byte == 8'h00))
    // a successful run ends on a workgroup byte
    `ASSERT_CLK(a_last_is_group, i_clk, i_rst_n, (o_out_valid && o_last_result && !o_status) |-> o_which_name)
    // a last byte is held while the previous run still drains
    `ASSERT_CLK(a_last_held, i_clk, i_rst_n, (r_in_valid && r_in_last && !emit_free) |=> (r_in_valid && r_in_last))
    // a loaded run shows its first word next cycle
    `ASSERT_CLK(a_load_shows, i_clk, i_rst_n, (take && r_in_last) |=> o_out_valid)

endmodule

@@ hw/rtl/nbs_parse.sv @@
module nbs_parse import nbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data,
    input  logic       i_first,
    input  logic       i_last,
    output t_snap      o_snap
);

    logic [7:0]       r_left, n_left;
    logic [POS_W-1:0] r_pos, n_pos;
    t_name            r_entry, n_entry;
    logic [7:0]       r_suffix, n_suffix;
    logic             r_group, n_group;
    t_name            r_host, n_host;
    t_name            r_gbuf, n_gbuf;
    t_name            r_fb, n_fb;
    logic             r_found_g, n_found_g;
    logic             r_found_h, n_found_h;
    logic             r_found_f, n_found_f;

    logic [NAME_LEN-1:0] all_nz;
    logic [NAME_LEN-1:0] any_ns;
    t_name               cut;
    logic                non_empty;

    // name byte kept if no zero up to it and a non-space at or after it
    always_comb begin
        for (int i = 0; i < NAME_LEN; i++) begin
            if (i == 0) begin
                all_nz[i] = (r_entry[i] != CHAR_NUL);
            end else begin
                all_nz[i] = all_nz[i-1] && (r_entry[i] != CHAR_NUL);
            end
        end
        for (int i = NAME_LEN - 1; i >= 0; i--) begin
            if (i == NAME_LEN - 1) begin
                any_ns[i] = (r_entry[i] != CHAR_SPACE);
            end else begin
                any_ns[i] = any_ns[i+1] || (r_entry[i] != CHAR_SPACE);
            end
        end
        for (int i = 0; i < NAME_LEN; i++) begin
            cut[i] = (all_nz[i] && any_ns[i]) ? r_entry[i] : CHAR_NUL;
        end
        non_empty = all_nz[0] && any_ns[0];
    end

    always_comb begin
        n_left    = r_left;
        n_pos     = r_pos;
        n_entry   = r_entry;
        n_suffix  = r_suffix;
        n_group   = r_group;
        n_host    = r_host;
        n_gbuf    = r_gbuf;
        n_fb      = r_fb;
        n_found_g = r_found_g;
        n_found_h = r_found_h;
        n_found_f = r_found_f;

        if (i_take) begin
            if (i_first) begin
                n_left    = i_data;
                n_pos     = '0;
                n_group   = 1'b0;
                n_found_g = 1'b0;
                n_found_h = 1'b0;
                n_found_f = 1'b0;
            end else if (r_left != 8'd0) begin
                if (r_pos < POS_SUFFIX) begin
                    n_entry[r_pos[IDX_W-1:0]] = i_data;
                end else if (r_pos == POS_SUFFIX) begin
                    n_suffix = i_data;
                end else if (r_pos == POS_FLAGS) begin
                    n_group = i_data[7];
                end
                if (r_pos == POS_LAST) begin
                    if (non_empty) begin
                        if (r_suffix == SUFFIX_WG && r_group && !r_found_g) begin
                            n_gbuf    = cut;
                            n_found_g = 1'b1;
                        end else if (r_suffix == SUFFIX_HOST && !r_group && !r_found_h) begin
                            n_host    = cut;
                            n_found_h = 1'b1;
                        end else if (r_suffix == SUFFIX_WG && !r_group && !r_found_f) begin
                            n_fb      = cut;
                            n_found_f = 1'b1;
                        end
                    end
                    n_left = r_left - 8'd1;
                    n_pos  = '0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end

        // results reflect the byte just taken
        o_snap.fail  = !n_found_h && !n_found_f;
        o_snap.host  = n_found_h ? n_host : n_fb;
        o_snap.group = n_found_g ? n_gbuf : DEFAULT_GROUP;

        if (i_take && i_last) begin
            n_left    = 8'd0;
            n_pos     = '0;
            n_group   = 1'b0;
            n_found_g = 1'b0;
            n_found_h = 1'b0;
            n_found_f = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= 8'd0;
            r_pos     <= '0;
            r_group   <= 1'b0;
            r_found_g <= 1'b0;
            r_found_h <= 1'b0;
            r_found_f <= 1'b0;
        end else begin
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_group   <= n_group;
            r_found_g <= n_found_g;
            r_found_h <= n_found_h;
            r_found_f <= n_found_f;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_suffix <= n_suffix;
        r_host   <= n_host;
        r_gbuf   <= n_gbuf;
        r_fb     <= n_fb;
    end

endmodule

@@ hw/rtl/nbs_emit.sv @@
module nbs_emit import nbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_snap      i_snap,
    input  logic       i_out_ready,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_which,
    output logic       o_status,
    output logic       o_last
);

    logic [RESULTS-1:0][7:0] r_sh, n_sh;
    logic [CNT_W-1:0]        r_left, n_left;
    logic                    r_which, n_which;
    logic                    r_status, n_status;
    logic                    r_last, n_last;

    // free once the final word of the run leaves
    assign o_free = (r_left == '0) || (r_left == CNT_W'(1) && i_out_ready);

    always_comb begin
        n_sh     = r_sh;
        n_left   = r_left;
        n_which  = r_which;
        n_status = r_status;
        n_last   = r_last;
        if (i_load) begin
            n_which = 1'b0;
            if (i_snap.fail) begin
                n_sh     = '0;
                n_left   = CNT_W'(1);
                n_status = 1'b1;
                n_last   = 1'b1;
            end else begin
                n_sh     = {i_snap.group, i_snap.host};
                n_left   = CNT_W'(RESULTS);
                n_status = 1'b0;
                n_last   = 1'b0;
            end
        end else if (r_left != '0 && i_out_ready) begin
            n_sh    = r_sh >> 8;
            n_left  = r_left - CNT_W'(1);
            n_which = (r_left <= CNT_W'(NAME_LEN + 1));
            n_last  = (r_left == CNT_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh     <= n_sh;
        r_which  <= n_which;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_valid  = (r_left != '0);
    assign o_byte   = r_sh[0];
    assign o_which  = r_which;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb import nbs_pkg::*;;

    localparam int    STALL_LIMIT = 4000;
    localparam int    TAIL_CYCLES = 16;
    localparam string WG_DEFAULT  = "WORKGROUP";

    typedef struct {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
        logic       hold;
    } t_table_word;

    typedef struct {
        logic [7:0] ch;
        logic       which;
        logic       fail;
        logic       final_w;
    } t_name_word;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_first_byte = 1'b0;
    logic       i_last_byte  = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_which_name;
    logic       o_status;
    logic       o_last_result;

    nbstat_name_table_picker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_which_name  (o_which_name),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    t_table_word table_in_q[$];
    t_name_word  names_due[$];
    logic [7:0]  run_q[$];

    int  send_idle_pct = 24;
    int  recv_idle_pct = 68;
    int  bytes_queued  = 0;
    int  bytes_taken   = 0;
    int  runs_closed   = 0;
    int  name_words    = 0;
    int  fail_words    = 0;
    int  mismatches    = 0;
    int  stall_cycles  = 0;
    bit  hold_next     = 1'b0;

    // picker state as seen by the predictor
    logic [7:0]       cnt_left;
    logic [POS_W-1:0] ent_pos;
    t_name            ent_chars;
    logic [7:0]       ent_sfx;
    logic             ent_grp;
    t_name            host_chars;
    t_name            wg_chars;
    t_name            alt_chars;
    logic             got_wg;
    logic             got_host;
    logic             got_alt;

    task automatic clear_names();
        cnt_left   = 8'h00;
        ent_pos    = '0;
        ent_sfx    = 8'h00;
        ent_grp    = 1'b0;
        host_chars = '0;
        wg_chars   = '0;
        alt_chars  = '0;
        got_wg     = 1'b0;
        got_host   = 1'b0;
        got_alt    = 1'b0;
    endtask

    function automatic t_name cut_name(int len);
        t_name n;
        for (int i = 0; i < NAME_LEN; i++)
            n[i] = (i < len) ? ent_chars[i] : CHAR_NUL;
        return n;
    endfunction

    task automatic settle_entry();
        int len;
        len = NAME_LEN;
        while (len > 0 && ent_chars[len-1] == CHAR_SPACE)
            len--;
        for (int i = 0; i < len; i++) begin
            if (ent_chars[i] == CHAR_NUL) begin
                len = i;
                break;
            end
        end
        if (len == 0)
            return;
        if (ent_sfx == SUFFIX_WG && ent_grp && !got_wg) begin
            wg_chars = cut_name(len);
            got_wg   = 1'b1;
        end else if (ent_sfx == SUFFIX_HOST && !ent_grp && !got_host) begin
            host_chars = cut_name(len);
            got_host   = 1'b1;
        end else if (ent_sfx == SUFFIX_WG && !ent_grp && !got_alt) begin
            alt_chars = cut_name(len);
            got_alt   = 1'b1;
        end
    endtask

    task automatic release_names();
        t_name_word w;
        t_name      pick;
        t_name      grp;
        if (!got_host && !got_alt) begin
            w.ch      = CHAR_NUL;
            w.which   = 1'b0;
            w.fail    = 1'b1;
            w.final_w = 1'b1;
            names_due.push_back(w);
            return;
        end
        pick = got_host ? host_chars : alt_chars;
        for (int i = 0; i < NAME_LEN; i++)
            grp[i] = (i < WG_DEFAULT.len()) ? WG_DEFAULT[i] : CHAR_NUL;
        if (got_wg)
            grp = wg_chars;
        for (int k = 0; k < RESULTS; k++) begin
            w.which   = (k >= NAME_LEN);
            w.ch      = w.which ? grp[k-NAME_LEN] : pick[k];
            w.fail    = 1'b0;
            w.final_w = (k == RESULTS - 1);
            names_due.push_back(w);
        end
    endtask

    task automatic track_table_byte(logic [7:0] b, logic is_first, logic is_last);
        if (is_first) begin
            clear_names();
            cnt_left = b;
        end else if (cnt_left != 0) begin
            if (ent_pos < NAME_LEN)
                ent_chars[ent_pos[IDX_W-1:0]] = b;
            else if (ent_pos == POS_SUFFIX)
                ent_sfx = b;
            else if (ent_pos == POS_FLAGS)
                ent_grp = b[7];
            if (ent_pos >= POS_LAST) begin
                settle_entry();
                cnt_left = cnt_left - 8'd1;
                ent_pos  = '0;
            end else begin
                ent_pos = ent_pos + POS_W'(1);
            end
        end
        if (is_last) begin
            release_names();
            clear_names();
            runs_closed++;
        end
    endtask

    task automatic queue_byte(logic [7:0] b, logic is_first, logic is_last);
        t_table_word w;
        w.data     = b;
        w.is_first = is_first;
        w.is_last  = is_last;
        w.hold     = hold_next;
        hold_next  = 1'b0;
        table_in_q.push_back(w);
        bytes_queued++;
    endtask

    task automatic flush_run(bit with_first, bit with_last);
        foreach (run_q[i])
            queue_byte(run_q[i], with_first && i == 0, with_last && i == run_q.size() - 1);
        run_q.delete();
    endtask

    task automatic add_entry();
        int         style;
        int         len;
        int         cut;
        logic [7:0] ch;
        style = $urandom_range(9);
        len   = $urandom_range(0, NAME_LEN);
        cut   = $urandom_range(0, NAME_LEN - 1);
        for (int i = 0; i < NAME_LEN; i++) begin
            if (style == 0)
                ch = 8'($urandom);
            else if (i >= len)
                ch = (style == 1) ? CHAR_NUL : CHAR_SPACE;
            else if (style == 2 && i == cut)
                ch = CHAR_NUL;
            else if (style == 3 && $urandom_range(3) == 0)
                ch = CHAR_SPACE;
            else if (style == 4)
                ch = 8'($urandom_range(1, 255));
            else
                ch = 8'($urandom_range(8'h21, 8'h7e));
            run_q.push_back(ch);
        end
        case ($urandom_range(4))
            0, 1:    run_q.push_back(SUFFIX_WG);
            2, 3:    run_q.push_back(SUFFIX_HOST);
            default: run_q.push_back(8'($urandom));
        endcase
        run_q.push_back({$urandom_range(1) == 1, 7'($urandom)});
        run_q.push_back(8'($urandom));
    endtask

    task automatic add_counted(int n);
        run_q.push_back(8'(n));
        repeat (n) add_entry();
    endtask

    task automatic add_random_run();
        int kind;
        int n;
        kind = $urandom_range(99);
        n    = $urandom_range(1, 3);
        if (kind < 68) begin
            add_counted(n);
        end else if (kind < 76) begin
            // statistics block after the counted entries
            add_counted(n);
            repeat ($urandom_range(1, 20)) run_q.push_back(8'($urandom));
        end else if (kind < 84) begin
            // count promises more than arrives, last entry cut short
            add_counted(n);
            run_q[0] = ($urandom_range(1) == 1) ? 8'hff : 8'(n + 1);
            add_entry();
            repeat ($urandom_range(1, ENTRY_BYTES - 1)) void'(run_q.pop_back());
        end else if (kind < 92) begin
            // table restarted part way through
            add_counted(n);
            repeat ($urandom_range(1, ENTRY_BYTES - 1)) void'(run_q.pop_back());
            flush_run(1'b1, 1'b0);
            add_counted($urandom_range(1, 3));
        end else if (kind < 96) begin
            add_counted(0);
            repeat ($urandom_range(0, 20)) run_q.push_back(8'($urandom));
        end else begin
            // last byte with no count byte since the previous run
            repeat ($urandom_range(1, 5)) run_q.push_back(8'($urandom));
            flush_run(1'b0, 1'b1);
            return;
        end
        flush_run(1'b1, 1'b1);
    endtask

    task automatic wait_bytes_taken();
        while (bytes_taken != bytes_queued)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_table
        t_table_word w;
        logic        stuck;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            stuck = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                track_table_byte(i_data_byte, i_first_byte, i_last_byte);
                bytes_taken++;
            end
            if (stuck) begin
                // word held until taken
            end else if (table_in_q.size() != 0
                         && (!table_in_q[0].hold || names_due.size() == 0)
                         && $urandom_range(99) >= send_idle_pct) begin
                w = table_in_q.pop_front();
                i_in_valid   <= 1'b1;
                i_data_byte  <= w.data;
                i_first_byte <= w.is_first;
                i_last_byte  <= w.is_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_names
        t_name_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (names_due.size() == 0) begin
                $display("%0t: word with none due: byte %h which %b status %b last %b",
                         $time, o_out_byte, o_which_name, o_status, o_last_result);
                mismatches++;
            end else begin
                w = names_due.pop_front();
                if (o_out_byte !== w.ch) begin
                    $display("%0t: out_byte expected %h got %h", $time, w.ch, o_out_byte);
                    mismatches++;
                end
                if (o_which_name !== w.which) begin
                    $display("%0t: which_name expected %b got %b",
                             $time, w.which, o_which_name);
                    mismatches++;
                end
                if (o_status !== w.fail) begin
                    $display("%0t: status expected %b got %b", $time, w.fail, o_status);
                    mismatches++;
                end
                if (o_last_result !== w.final_w) begin
                    $display("%0t: last_result expected %b got %b",
                             $time, w.final_w, o_last_result);
                    mismatches++;
                end
                if (w.fail)
                    fail_words++;
                else
                    name_words++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("nbstat_name_table_picker: mismatch");
                $finish;
            end
        end
    end

    initial begin
        clear_names();
        ent_chars = '0;

        // bytes before any count byte are dropped
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // count and last on one byte
        queue_byte(8'hff, 1'b1, 1'b1);
        // last byte straight after a finished run
        queue_byte(8'h5a, 1'b0, 1'b1);
        // one full-width host name of 0xff characters
        run_q.push_back(8'd1);
        repeat (NAME_LEN) run_q.push_back(8'hff);
        run_q.push_back(SUFFIX_HOST);
        run_q.push_back(8'h7f);
        run_q.push_back(8'hff);
        flush_run(1'b1, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_queued < 110)
            add_random_run();
        wait_bytes_taken();

        send_idle_pct <= 68;
        recv_idle_pct <= 24;
        // sender waits for all pending names before this run
        hold_next = 1'b1;
        while (bytes_queued < 220)
            add_random_run();
        wait_bytes_taken();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        while (bytes_queued < 330)
            add_random_run();
        wait_bytes_taken();

        while (names_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d table bytes over %0d runs under three stall mixes", bytes_taken,
                 runs_closed);
        $display("checked %0d name words and %0d failure words", name_words, fail_words);
        if (mismatches == 0)
            $display("nbstat_name_table_picker: match");
        else
            $display("nbstat_name_table_picker: mismatch");
        $finish;
    end

endmodule
